// ===== design/sem_pkg.sv =====
// Shared constants and types for the Sobel RGB edge magnitude core.
// No dependencies; compile first.
package sem_pkg;

	localparam int unsigned PIX_W         = 8;
	localparam int unsigned RGB_W         = 3 * PIX_W;
	localparam int unsigned CFG_W_W       = 11;
	localparam int unsigned CFG_H_W       = 16;
	localparam int unsigned ROW_W         = CFG_H_W + 1;
	localparam int unsigned PADDR_W       = 3;
	localparam int unsigned PDATA_W       = 32;
	localparam int unsigned MAX_WIDTH_DEF = 1024;

	localparam logic [CFG_W_W-1:0] WIDTH_RESET  = CFG_W_W'(640);
	localparam logic [CFG_H_W-1:0] HEIGHT_RESET = CFG_H_W'(480);

	localparam int unsigned GRAD_W   = 11;
	localparam int unsigned SUM_W    = 21;
	localparam int unsigned ROOT_W   = 8;
	localparam int unsigned RK_W     = $clog2(ROOT_W);
	localparam int unsigned ROOT_MAX = (1 << ROOT_W) - 1;
	localparam logic [SUM_W-1:0] SAT_LIMIT = SUM_W'(ROOT_MAX * ROOT_MAX + ROOT_MAX);

	typedef struct packed {
		logic                       start;
		logic [2:0][SUM_W-1:0]      sum;
	} root_ctl_t;

	typedef struct packed {
		logic                       done;
		logic [2:0][ROOT_W-1:0]     mag;
	} root_stat_t;

endpackage

// ===== design/sem_if.sv =====
// Stream channel interfaces for the Sobel RGB edge magnitude core.
// Depends on sem_pkg.
interface sem_pixel_if;
	import sem_pkg::*;
	logic             valid;
	logic             ready;
	logic             action;
	logic [PIX_W-1:0] pix_red;
	logic [PIX_W-1:0] pix_green;
	logic [PIX_W-1:0] pix_blue;

	modport source (output valid, action, pix_red, pix_green, pix_blue, input ready);
	modport sink   (input valid, action, pix_red, pix_green, pix_blue, output ready);
endinterface

interface sem_result_if;
	import sem_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] edge_red;
	logic [PIX_W-1:0] edge_green;
	logic [PIX_W-1:0] edge_blue;
	logic             frame_done;

	modport source (output valid, edge_red, edge_green, edge_blue, frame_done, input ready);
	modport sink   (input valid, edge_red, edge_green, edge_blue, frame_done, output ready);
endinterface

// ===== design/sem_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module sem_ram #(
	parameter int unsigned WIDTH = 24,
	parameter int unsigned DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== design/sem_root.sv =====
// Three-lane iterative rounded square root, one result bit per cycle,
// saturated at 255. Depends on sem_pkg.
module sem_root (
	input  logic                clk,
	input  logic                arst_n,
	input  sem_pkg::root_ctl_t  ctl,
	output sem_pkg::root_stat_t stat
);
	import sem_pkg::*;

	typedef enum logic [1:0] {R_IDLE, R_ITER, R_ROUND} rstate_t;

	rstate_t                 state_q;
	logic [RK_W-1:0]         k_q;
	logic                    done_q;
	logic [SUM_W-1:0]        s_q [3];
	logic [ROOT_W-1:0]       m_q [3];
	logic [ROOT_W-1:0]       m_step [3];
	logic [ROOT_W-1:0]       m_fin [3];
	logic [2:0][ROOT_W-1:0]  mag_q;

	always_comb begin
		logic [ROOT_W-1:0]     t;
		logic [2*ROOT_W-1:0]   tsq;
		logic [2*ROOT_W:0]     mm;
		logic [2*ROOT_W:0]     rnd;
		for (int c = 0; c < 3; c++) begin
			t         = m_q[c] | (ROOT_W'(1) << k_q);
			tsq       = t * t;
			m_step[c] = (SUM_W'(tsq) <= s_q[c]) ? t : m_q[c];
			mm        = (2*ROOT_W+1)'(m_q[c]);
			rnd       = mm * mm + mm;
			if (s_q[c] > SAT_LIMIT) begin
				m_fin[c] = ROOT_W'(ROOT_MAX);
			end else if (s_q[c] > SUM_W'(rnd)) begin
				m_fin[c] = m_q[c] + 1'b1;
			end else begin
				m_fin[c] = m_q[c];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= R_IDLE;
			k_q     <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				R_IDLE: begin
					if (ctl.start) begin
						k_q     <= RK_W'(ROOT_W - 1);
						state_q <= R_ITER;
					end
				end
				R_ITER: begin
					if (k_q == '0) begin
						state_q <= R_ROUND;
					end else begin
						k_q <= k_q - 1'b1;
					end
				end
				R_ROUND: begin
					done_q  <= 1'b1;
					state_q <= R_IDLE;
				end
				default: state_q <= R_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			case (state_q)
				R_IDLE: begin
					if (ctl.start) begin
						s_q[c] <= ctl.sum[c];
						m_q[c] <= '0;
					end
				end
				R_ITER:  m_q[c]   <= m_step[c];
				R_ROUND: mag_q[c] <= m_fin[c];
				default: ;
			endcase
		end
	end

	assign stat.done = done_q;
	assign stat.mag  = mag_q;

endmodule

// ===== design/sobel_edge_magnitude_rgb_core.sv =====
// Top level of the 3x3 Sobel RGB edge magnitude core: line stores, window,
// gradient/square datapath and sequencer. Depends on sem_pkg, sem_if, sem_ram, sem_root.
//
//  channel  | kind           | moves
//  ---------+----------------+---------------------------------------------
//  pixel    | valid/ready in | action, pix_red, pix_green, pix_blue
//  result   | valid/ready out| edge_red, edge_green, edge_blue, frame_done
//  apb      | APB slave      | frame_width @0x0, frame_height @0x4
//
// One pixel transaction at a time. A pixel that yields no result returns to idle
// after LOAD; one that yields a result passes GRAD, SQX, SQY and the eight bit
// steps plus rounding of the shared three-lane root unit to the output register.
// The output register decouples the result side: the next pixel is taken while
// a result waits. Async active-low reset; line stores need no clearing.
module sobel_edge_magnitude_rgb_core #(
	parameter int unsigned MAX_WIDTH = sem_pkg::MAX_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	sem_pixel_if.sink                    pixel,
	sem_result_if.source                 result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [sem_pkg::PADDR_W-1:0]  paddr,
	input  logic [sem_pkg::PDATA_W-1:0]  pwdata,
	output logic [sem_pkg::PDATA_W-1:0]  prdata,
	output logic                         pready
);
	import sem_pkg::*;

	localparam int unsigned XW    = $clog2(MAX_WIDTH);
	localparam int unsigned CW    = ((XW > CFG_W_W) ? XW : CFG_W_W) + 1;
	localparam int unsigned ACC_W = GRAD_W + 2;
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE, ST_LOAD, ST_GRAD, ST_SQX, ST_SQY, ST_ROOT, ST_OUT
	} state_t;

	state_t               state_q;
	logic [CFG_W_W-1:0]   frame_width_q;
	logic [CFG_H_W-1:0]   frame_height_q;
	logic [XW-1:0]        col_q;
	logic [ROW_W-1:0]     row_q;
	logic                 start_q;
	logic                 res_valid_q;
	logic                 res_done_q;
	logic [PIX_W-1:0]     res_red_q;
	logic [PIX_W-1:0]     res_green_q;
	logic [PIX_W-1:0]     res_blue_q;

	logic [RGB_W-1:0]     v_q;
	logic [2:0][2:0][RGB_W-1:0] win_q;
	logic                 mask_top_q;
	logic                 mask_bot_q;
	logic                 mask_left_q;
	logic                 mask_right_q;
	logic                 last_q;
	logic signed [GRAD_W-1:0] gx_q [3];
	logic signed [GRAD_W-1:0] gy_q [3];
	logic [SUM_W-1:0]     sum_q [3];

	logic [CFG_W_W-1:0]   w_eff;
	logic [CFG_H_W-1:0]   h_eff;
	logic                 in_fire;
	logic                 out_load;
	logic                 apb_wr;
	logic [RGB_W-1:0]     up_rdata;
	logic [RGB_W-1:0]     lo_rdata;
	logic                 emit_a;
	logic                 emit_b;
	logic                 top_d;
	logic                 bot_d;
	logic                 left_d;
	logic                 last_col;
	logic [ROW_W-1:0]     h_ext;
	logic [2:0][2:0][RGB_W-1:0] mwin;
	logic signed [GRAD_W-1:0] gx_d [3];
	logic signed [GRAD_W-1:0] gy_d [3];
	logic [SUM_W-1:0]     sqx [3];
	logic [SUM_W-1:0]     sqy [3];
	root_ctl_t            root_ctl;
	root_stat_t           root_stat;

	// effective frame size
	always_comb begin
		if (frame_width_q == '0) begin
			w_eff = CFG_W_W'(1);
		end else if (32'(frame_width_q) > MAX_WIDTH) begin
			w_eff = CFG_W_W'(MAX_WIDTH);
		end else begin
			w_eff = frame_width_q;
		end
		h_eff = (frame_height_q == '0) ? CFG_H_W'(1) : frame_height_q;
	end

	assign h_ext    = ROW_W'(h_eff);
	assign in_fire  = pixel.valid && pixel.ready;
	assign out_load = (state_q == ST_OUT) && (!res_valid_q || result.ready);
	assign apb_wr   = psel && penable && pwrite && pready;
	assign pready   = 1'b1;
	assign pixel.ready = (state_q == ST_IDLE);

	always_comb begin
		unique case (paddr[2])
			REG_WIDTH:  prdata = PDATA_W'(frame_width_q);
			REG_HEIGHT: prdata = PDATA_W'(frame_height_q);
			default:    prdata = '0;
		endcase
	end

	// position decode for the item in LOAD
	always_comb begin
		emit_a   = (col_q != '0) && (row_q >= ROW_W'(1));
		emit_b   = (col_q == '0) && (row_q >= ROW_W'(2));
		top_d    = emit_a ? (row_q == ROW_W'(1)) : (row_q == ROW_W'(2));
		bot_d    = emit_a ? (row_q == h_ext) : (row_q == h_ext + ROW_W'(1));
		left_d   = emit_a ? (col_q == XW'(1)) : (w_eff == CFG_W_W'(1));
		last_col = (CW'(col_q) + CW'(1)) == CW'(w_eff);
	end

	sem_ram #(.WIDTH(RGB_W), .DEPTH(MAX_WIDTH)) u_ram_upper (
		.clk   (clk),
		.we    (state_q == ST_LOAD),
		.waddr (col_q),
		.wdata (lo_rdata),
		.re    (in_fire),
		.raddr (col_q),
		.rdata (up_rdata)
	);

	sem_ram #(.WIDTH(RGB_W), .DEPTH(MAX_WIDTH)) u_ram_lower (
		.clk   (clk),
		.we    (state_q == ST_LOAD),
		.waddr (col_q),
		.wdata (v_q),
		.re    (in_fire),
		.raddr (col_q),
		.rdata (lo_rdata)
	);

	// masked window, gradients, squares
	always_comb begin
		logic signed [ACC_W-1:0] p [3][3];
		logic signed [ACC_W-1:0] gxw;
		logic signed [ACC_W-1:0] gyw;
		logic signed [2*GRAD_W-1:0] px;
		logic signed [2*GRAD_W-1:0] py;
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				if ((i == 0 && mask_top_q) || (i == 2 && mask_bot_q) ||
				    (j == 0 && mask_left_q) || (j == 2 && mask_right_q)) begin
					mwin[i][j] = '0;
				end else begin
					mwin[i][j] = win_q[i][j];
				end
			end
		end
		for (int c = 0; c < 3; c++) begin
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					p[i][j] = $signed(ACC_W'(mwin[i][j][PIX_W*(2-c) +: PIX_W]));
				end
			end
			gxw = (p[0][2] - p[0][0]) + ((p[1][2] - p[1][0]) <<< 1) + (p[2][2] - p[2][0]);
			gyw = (p[2][0] + (p[2][1] <<< 1) + p[2][2]) - (p[0][0] + (p[0][1] <<< 1) + p[0][2]);
			gx_d[c] = GRAD_W'(gxw);
			gy_d[c] = GRAD_W'(gyw);
			px      = gx_q[c] * gx_q[c];
			py      = gy_q[c] * gy_q[c];
			sqx[c]  = SUM_W'(px);
			sqy[c]  = SUM_W'(py);
		end
	end

	always_comb begin
		root_ctl.start = start_q;
		for (int c = 0; c < 3; c++) begin
			root_ctl.sum[c] = sum_q[c];
		end
	end

	sem_root u_root (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (root_ctl),
		.stat   (root_stat)
	);

	// sequencer, counters, config and result handshake
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			frame_width_q  <= WIDTH_RESET;
			frame_height_q <= HEIGHT_RESET;
			col_q          <= '0;
			row_q          <= '0;
			start_q        <= 1'b0;
			res_valid_q    <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_fire) begin
						state_q <= ST_LOAD;
					end
				end
				ST_LOAD: begin
					if (emit_b && bot_d) begin
						col_q <= '0;
						row_q <= '0;
					end else if (last_col) begin
						col_q <= '0;
						row_q <= row_q + 1'b1;
					end else begin
						col_q <= col_q + 1'b1;
					end
					state_q <= (emit_a || emit_b) ? ST_GRAD : ST_IDLE;
				end
				ST_GRAD: state_q <= ST_SQX;
				ST_SQX:  state_q <= ST_SQY;
				ST_SQY: begin
					start_q <= 1'b1;
					state_q <= ST_ROOT;
				end
				ST_ROOT: begin
					start_q <= 1'b0;
					if (root_stat.done) begin
						state_q <= ST_OUT;
					end
				end
				ST_OUT: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (out_load) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			if (apb_wr) begin
				unique case (paddr[2])
					REG_WIDTH:  frame_width_q  <= pwdata[CFG_W_W-1:0];
					REG_HEIGHT: frame_height_q <= pwdata[CFG_H_W-1:0];
					default: ;
				endcase
				col_q <= '0;
				row_q <= '0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		if (in_fire) begin
			if (!pixel.action && (row_q < h_ext)) begin
				v_q <= {pixel.pix_red, pixel.pix_green, pixel.pix_blue};
			end else begin
				v_q <= '0;
			end
		end
		if (state_q == ST_LOAD) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i][0] <= win_q[i][1];
				win_q[i][1] <= win_q[i][2];
			end
			win_q[0][2]  <= up_rdata;
			win_q[1][2]  <= lo_rdata;
			win_q[2][2]  <= v_q;
			mask_top_q   <= top_d;
			mask_bot_q   <= bot_d;
			mask_left_q  <= left_d;
			mask_right_q <= emit_b;
			last_q       <= emit_b && bot_d;
		end
		for (int c = 0; c < 3; c++) begin
			if (state_q == ST_GRAD) begin
				gx_q[c] <= gx_d[c];
				gy_q[c] <= gy_d[c];
			end
			if (state_q == ST_SQX) begin
				sum_q[c] <= sqx[c];
			end
			if (state_q == ST_SQY) begin
				sum_q[c] <= sum_q[c] + sqy[c];
			end
		end
		if (out_load) begin
			res_red_q   <= root_stat.mag[0];
			res_green_q <= root_stat.mag[1];
			res_blue_q  <= root_stat.mag[2];
			res_done_q  <= last_q;
		end
	end

	assign result.valid      = res_valid_q;
	assign result.edge_red   = res_red_q;
	assign result.edge_green = res_green_q;
	assign result.edge_blue  = res_blue_q;
	assign result.frame_done = res_done_q;

endmodule

// ===== design/sem_checker.sv =====
// Port-level checks for the Sobel RGB edge magnitude core, bound to the top.
// Depends on sobel_edge_magnitude_rgb_core.
module sem_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_ready,
	input logic       out_valid,
	input logic       out_ready,
	input logic [7:0] out_red,
	input logic [7:0] out_green,
	input logic [7:0] out_blue,
	input logic       out_done
);

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid &&
			$stable({out_red, out_green, out_blue, out_done}))
		else $error("result changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("pixel taken while a transaction is in work");

	a_min_latency: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !$rose(out_valid) ##1 !$rose(out_valid))
		else $error("result appeared too soon after a pixel");

	a_result_from_work: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared while the core was idle");

endmodule

bind sobel_edge_magnitude_rgb_core sem_checker u_sem_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (pixel.valid),
	.in_ready  (pixel.ready),
	.out_valid (result.valid),
	.out_ready (result.ready),
	.out_red   (result.edge_red),
	.out_green (result.edge_green),
	.out_blue  (result.edge_blue),
	.out_done  (result.frame_done)
);

// ===== sim/sobel_edge_magnitude_rgb_core_test.sv =====
// Self-checking testbench for sobel_edge_magnitude_rgb_core: streams RGB frames of many
// sizes, predicts every edge magnitude in a scoreboard and checks each result transaction.
// Depends on sem_pkg, sem_if and the core RTL.
module sobel_edge_magnitude_rgb_core_test;
	timeunit 1ns;
	timeprecision 1ps;
	import sem_pkg::*;

	localparam int HALF_PERIOD   = 5;
	localparam int RESET_CYCLES  = 11;
	localparam int RANDOM_ITEMS  = 450;
	localparam int WIDE_ITEMS    = 1040;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES   = 400;
	localparam int HOLD_AFTER    = 150;
	localparam int REPORT_LIMIT  = 10;
	localparam longint LIMIT_NS  = 5_000_000;

	localparam logic [PADDR_W-1:0] ADDR_WIDTH  = PADDR_W'(0);
	localparam logic [PADDR_W-1:0] ADDR_HEIGHT = PADDR_W'(4);

	typedef enum logic {ACT_PIXEL = 1'b0, ACT_DRAIN = 1'b1} action_e;

	typedef struct {
		logic [PIX_W-1:0] red;
		logic [PIX_W-1:0] green;
		logic [PIX_W-1:0] blue;
		logic             done;
	} edge_px_t;

	class edge_scoreboard;
		logic [CFG_W_W-1:0] width_reg;
		logic [CFG_H_W-1:0] height_reg;
		// last four frame rows, indexed by row modulo 4
		logic [RGB_W-1:0]   rows [4][MAX_WIDTH_DEF];
		int unsigned        col;
		int unsigned        row;
		edge_px_t           owed_edges[$];
		int unsigned        mismatches;

		function new();
			width_reg  = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			col        = 0;
			row        = 0;
			mismatches = 0;
		endfunction

		function int frame_w();
			if (width_reg == 0) return 1;
			if (width_reg > MAX_WIDTH_DEF) return MAX_WIDTH_DEF;
			return int'(width_reg);
		endfunction

		function int frame_h();
			return (height_reg == 0) ? 1 : int'(height_reg);
		endfunction

		function void flag(string msg);
			mismatches++;
			if (mismatches <= REPORT_LIMIT) $display("%s", msg);
		endfunction

		function void write_reg(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
			if (addr == ADDR_WIDTH) width_reg = data[CFG_W_W-1:0];
			else if (addr == ADDR_HEIGHT) height_reg = data[CFG_H_W-1:0];
			else return;
			col = 0;
			row = 0;
		endfunction

		// lane 2 red, 1 green, 0 blue
		function logic [PIX_W-1:0] magnitude(int rc, int cc, int lane);
			int w, h, gx, gy, rn, cn, p, s, m, t;
			w  = frame_w();
			h  = frame_h();
			gx = 0;
			gy = 0;
			for (int dy = -1; dy <= 1; dy++) begin
				for (int dx = -1; dx <= 1; dx++) begin
					rn = rc + dy;
					cn = cc + dx;
					if (rn >= 0 && rn < h && cn >= 0 && cn < w) begin
						p = int'(rows[rn % 4][cn][lane*PIX_W +: PIX_W]);
						gx += p * dx * ((dy == 0) ? 2 : 1);
						gy += p * dy * ((dx == 0) ? 2 : 1);
					end
				end
			end
			s = gx * gx + gy * gy;
			m = 0;
			for (int b = 11; b >= 0; b--) begin
				t = m | (1 << b);
				if (t * t <= s) m = t;
			end
			if (s > m * m + m) m++;
			if (m > int'(ROOT_MAX)) m = int'(ROOT_MAX);
			return PIX_W'(m);
		endfunction

		function void take_pixel(action_e act, logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
				logic [PIX_W-1:0] b);
			int w, h, rc, cc;
			bit fires;
			edge_px_t e;
			w     = frame_w();
			h     = frame_h();
			fires = 0;
			rc    = 0;
			cc    = 0;
			rows[row % 4][col] = (act == ACT_PIXEL && row < h) ? {r, g, b} : '0;
			if (col >= 1 && row >= 1) begin
				fires = 1;
				rc    = int'(row) - 1;
				cc    = int'(col) - 1;
			end else if (col == 0 && row >= 2) begin
				fires = 1;
				rc    = int'(row) - 2;
				cc    = w - 1;
			end
			col++;
			if (col >= w) begin
				col = 0;
				row++;
			end
			if (fires) begin
				e.red   = magnitude(rc, cc, 2);
				e.green = magnitude(rc, cc, 1);
				e.blue  = magnitude(rc, cc, 0);
				e.done  = (rc == h - 1 && cc == w - 1);
				owed_edges.push_back(e);
				if (e.done) begin
					col = 0;
					row = 0;
				end
			end
		endfunction

		function void match_edge(logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
				logic [PIX_W-1:0] b, logic done);
			edge_px_t e;
			if (owed_edges.size() == 0) begin
				flag($sformatf("unexpected result r=%0d g=%0d b=%0d done=%0b", r, g, b, done));
				return;
			end
			e = owed_edges.pop_front();
			if (r !== e.red || g !== e.green || b !== e.blue || done !== e.done)
				flag($sformatf("edge mismatch: exp r=%0d g=%0d b=%0d done=%0b, got r=%0d g=%0d b=%0d done=%0b",
					e.red, e.green, e.blue, e.done, r, g, b, done));
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;

	int send_run;
	int take_run;
	int results_taken;

	edge_scoreboard edges = new();

	sem_pixel_if  pixel_ch();
	sem_result_if result_ch();

	sobel_edge_magnitude_rgb_core uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.pixel   (pixel_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	always @(posedge clk) begin
		if (arst_n && pixel_ch.valid && pixel_ch.ready)
			edges.take_pixel(action_e'(pixel_ch.action), pixel_ch.pix_red,
				pixel_ch.pix_green, pixel_ch.pix_blue);
		if (arst_n && result_ch.valid && result_ch.ready)
			edges.match_edge(result_ch.edge_red, result_ch.edge_green,
				result_ch.edge_blue, result_ch.frame_done);
		if (arst_n && psel && penable && pwrite && pready)
			edges.write_reg(paddr, pwdata);
	end

	// idle cycles before the next transaction, with occasional runs of none
	function automatic int draw_gap(inout int run);
		if (run > 0) begin
			run--;
			return 0;
		end
		if ($urandom_range(0, 15) == 0) begin
			run = $urandom_range(10, 40);
			return 0;
		end
		return $urandom_range(0, 3);
	endfunction

	function automatic logic [PIX_W-1:0] rand_comp();
		case ($urandom_range(0, 7))
			0: return '0;
			1: return '1;
			default: return PIX_W'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic int eff_size(int unsigned raw, int unsigned cap);
		if (raw == 0) return 1;
		return (raw > cap) ? int'(cap) : int'(raw);
	endfunction

	task automatic send(action_e act, logic [PIX_W-1:0] r, logic [PIX_W-1:0] g,
			logic [PIX_W-1:0] b);
		int gap;
		gap = draw_gap(send_run);
		if (gap > 0) begin
			pixel_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pixel_ch.valid     <= 1'b1;
		pixel_ch.action    <= act;
		pixel_ch.pix_red   <= r;
		pixel_ch.pix_green <= g;
		pixel_ch.pix_blue  <= b;
		do @(posedge clk); while (!pixel_ch.ready);
	endtask

	task automatic send_frame(int w, int h);
		action_e act;
		for (int i = 0; i < w * h; i++) begin
			act = ($urandom_range(0, 19) == 0) ? ACT_DRAIN : ACT_PIXEL;
			send(act, rand_comp(), rand_comp(), rand_comp());
		end
		for (int i = 0; i <= w; i++) begin
			act = ($urandom_range(0, 3) == 0) ? ACT_PIXEL : ACT_DRAIN;
			send(act, rand_comp(), rand_comp(), rand_comp());
		end
	endtask

	task automatic settle();
		pixel_ch.valid <= 1'b0;
		do @(posedge clk); while (edges.owed_edges.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(logic [PADDR_W-1:0] addr, logic [PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
	endtask

	task automatic apb_read(logic [PADDR_W-1:0] addr, output logic [PDATA_W-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= addr;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		data = prdata;
	endtask

	task automatic set_frame(int unsigned w_raw, int unsigned h_raw);
		logic [PDATA_W-1:0] got;
		logic [PDATA_W-1:0] w_word;
		logic [PDATA_W-1:0] h_word;
		w_word = PDATA_W'(w_raw[CFG_W_W-1:0]);
		h_word = PDATA_W'(h_raw[CFG_H_W-1:0]);
		apb_write(ADDR_WIDTH, w_word);
		apb_read(ADDR_WIDTH, got);
		if (got !== w_word)
			edges.flag($sformatf("frame_width readback: exp %0d got %0d", w_word, got));
		apb_write(ADDR_HEIGHT, h_word);
		apb_read(ADDR_HEIGHT, got);
		if (got !== h_word)
			edges.flag($sformatf("frame_height readback: exp %0d got %0d", h_word, got));
		psel    <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	initial begin
		int take_gap;
		bit held;
		held          = 0;
		take_run      = 0;
		results_taken = 0;
		result_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			take_gap = draw_gap(take_run);
			// one long back-pressure stretch so the core fills and stalls its input
			if (!held && results_taken >= HOLD_AFTER) begin
				held     = 1;
				take_gap = HOLD_CYCLES;
			end
			if (take_gap > 0) begin
				result_ch.ready <= 1'b0;
				repeat (take_gap) @(posedge clk);
			end
			result_ch.ready <= 1'b1;
			do @(posedge clk); while (!result_ch.valid);
			results_taken++;
		end
	end

	initial begin
		logic [RGB_W-1:0] demo [9];
		int unsigned w_raw;
		int unsigned h_raw;
		int w;
		int h;
		int n;
		int sent_small;
		demo = '{24'hFFFFFF, 24'h000000, 24'hFF0080,
			24'h000000, 24'hFFFFFF, 24'h00FF00,
			24'h000000, 24'hFFFFFF, 24'h0180FE};
		send_run   = 0;
		sent_small = 0;
		arst_n             <= 1'b0;
		pixel_ch.valid     <= 1'b0;
		pixel_ch.action    <= ACT_PIXEL;
		pixel_ch.pix_red   <= '0;
		pixel_ch.pix_green <= '0;
		pixel_ch.pix_blue  <= '0;
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= '0;
		pwdata  <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// 3x3 frame: saturating edges, a drain inside the frame, a pixel in the padding
		set_frame(3, 3);
		for (int i = 0; i < 9; i++) begin
			if (i == 3) send(ACT_DRAIN, 8'hA5, 8'h5A, 8'hC3);
			else send(ACT_PIXEL, demo[i][23:16], demo[i][15:8], demo[i][7:0]);
		end
		send(ACT_DRAIN, 8'hFF, 8'hFF, 8'hFF);
		send(ACT_PIXEL, 8'hC8, 8'h37, 8'h99);
		send(ACT_DRAIN, 8'h00, 8'h00, 8'h00);
		send(ACT_DRAIN, 8'h12, 8'h34, 8'h56);
		settle();

		// zero width and height act as one
		set_frame(0, 0);
		send(ACT_PIXEL, 8'hFF, 8'hFF, 8'hFF);
		send(ACT_PIXEL, 8'h12, 8'h34, 8'h56);
		send(ACT_DRAIN, 8'h00, 8'h00, 8'h00);
		settle();

		// oversized width clamps to the line store depth; tallest height
		set_frame(2047, 65535);
		repeat (WIDE_ITEMS) send(ACT_PIXEL, rand_comp(), rand_comp(), rand_comp());
		settle();

		while (sent_small < RANDOM_ITEMS) begin
			case ($urandom_range(0, 9))
				0: w_raw = 0;
				1: w_raw = 1;
				2: w_raw = 2;
				3: w_raw = $urandom_range(13, 40);
				default: w_raw = $urandom_range(3, 12);
			endcase
			case ($urandom_range(0, 9))
				0: h_raw = 0;
				1: h_raw = 1;
				2: h_raw = $urandom_range(7, 24);
				default: h_raw = $urandom_range(2, 6);
			endcase
			if (w_raw > 12 && h_raw > 4) h_raw = $urandom_range(1, 4);
			set_frame(w_raw, h_raw);
			w = eff_size(w_raw, MAX_WIDTH_DEF);
			h = eff_size(h_raw, 65535);
			if ($urandom_range(0, 5) == 0) begin
				// broken stream: random actions, cut short by the next config write
				n = $urandom_range(1, w * h + w + 1);
				repeat (n) send(action_e'($urandom_range(0, 1)), rand_comp(), rand_comp(),
					rand_comp());
				sent_small += n;
			end else begin
				repeat ($urandom_range(1, 3)) begin
					send_frame(w, h);
					sent_small += w * h + w + 1;
				end
			end
			settle();
		end

		if (edges.mismatches == 0 && edges.owed_edges.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	initial begin
		#(LIMIT_NS);
		$display("FAILURE");
		$finish;
	end

endmodule
